>>> hw/rtl/rid_pkg.sv
package rid_pkg;

  localparam int unsigned HistDepth = 128;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned CntW      = $clog2(HistDepth + 1);
  localparam int unsigned IdW       = 64;
  localparam int unsigned AttW      = 4;

  localparam logic [AttW-1:0] MaxAttemptsReset = AttW'(8);

  typedef enum logic [2:0] {
    STATUS_ACCEPTED    = 3'd0,
    STATUS_RETRY_ZERO  = 3'd1,
    STATUS_RETRY_DUP   = 3'd2,
    STATUS_SOURCE_FAIL = 3'd3,
    STATUS_EXHAUSTED   = 3'd4
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

endpackage

>>> hw/rtl/recent_id_duplicate_filter_top.sv
// Recent-identifier duplicate filter.
//
// An item is a 128-bit candidate identifier (id_high_i, id_low_i) with a
// source_ok_i flag, taken at a rising edge where start is high and busy is
// low. Each item gives exactly one status on status_o, marked by a
// one-cycle result_valid_o strobe. The receiver cannot stall, so a status
// is marked valid for that single cycle only.
// A failed source or an all-zero candidate is answered in the cycle after the
// item is taken, and the block stays ready. Any other candidate is searched
// against the stored history, one entry per cycle through a single read
// port of the history memory and one 128-bit comparator. Each entry is read
// into a register before it is compared with the registered candidate, and
// the status is registered from that comparison.
// A search stops early on the first match.
// The max_attempts register is written through cfg_valid_i, cfg_ready_o and
// cfg_data_i while the block is idle. Reset empties the history, clears the
// attempt count and loads max_attempts with 8; the memory itself needs no
// clearing pass because only written entries are ever read.
module recent_id_duplicate_filter_top
  import rid_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [IdW-1:0]   id_high_i,
  input  logic [IdW-1:0]   id_low_i,
  input  logic             source_ok_i,
  output logic             result_valid_o,
  output logic [2:0]       status_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AttW-1:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [2*IdW-1:0]  mem_q [HistDepth];
  logic [2*IdW-1:0]  rdata_q;
  logic [2*IdW-1:0]  cand_q;
  logic [CntW-1:0]   idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [HistAw-1:0] oldest_q, oldest_d;
  logic [AttW-1:0]   attempt_q, attempt_d;
  logic [AttW-1:0]   max_att_q;
  logic              strobe_q, strobe_d;
  status_e           status_q, status_d;

  logic              take;
  logic              rd_en;
  logic              hit;
  logic              miss;
  logic              wr_en;
  logic [HistAw-1:0] wr_addr;
  logic [AttW-1:0]   att_inc;
  logic              att_final;

  assign busy           = (state_q != ST_IDLE);
  assign take           = start && !busy;
  assign cfg_ready_o    = !busy;
  assign result_valid_o = strobe_q;
  assign status_o       = status_q;

  assign rd_en     = (state_q == ST_SEARCH) && (idx_q < count_q);
  assign hit       = (state_q == ST_SEARCH) && cmp_vld_q && (rdata_q == cand_q);
  assign miss      = (state_q == ST_SEARCH) && !rd_en && !hit;
  assign att_inc   = attempt_q + AttW'(1);
  assign att_final = (att_inc >= max_att_q) || (att_inc == '0);
  assign wr_en     = miss;
  assign wr_addr   = (count_q < CntW'(HistDepth)) ? count_q[HistAw-1:0] : oldest_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && source_ok_i && ((id_high_i | id_low_i) != '0)) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit || miss) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d     = idx_q;
    cmp_vld_d = 1'b0;
    count_d   = count_q;
    oldest_d  = oldest_q;
    attempt_d = attempt_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (take) begin
          if (!source_ok_i) begin
            strobe_d  = 1'b1;
            status_d  = STATUS_SOURCE_FAIL;
            attempt_d = '0;
          end else if ((id_high_i | id_low_i) == '0) begin
            strobe_d  = 1'b1;
            status_d  = att_final ? STATUS_EXHAUSTED : STATUS_RETRY_ZERO;
            attempt_d = att_final ? '0 : att_inc;
          end
        end
      end
      ST_SEARCH: begin
        if (rd_en) begin
          idx_d = idx_q + CntW'(1);
        end
        cmp_vld_d = rd_en && !hit;
        if (hit) begin
          strobe_d  = 1'b1;
          status_d  = att_final ? STATUS_EXHAUSTED : STATUS_RETRY_DUP;
          attempt_d = att_final ? '0 : att_inc;
        end else if (miss) begin
          strobe_d  = 1'b1;
          status_d  = STATUS_ACCEPTED;
          attempt_d = '0;
          if (count_q < CntW'(HistDepth)) begin
            count_d = count_q + CntW'(1);
          end else if (oldest_q == HistAw'(HistDepth - 1)) begin
            oldest_d = '0;
          end else begin
            oldest_d = oldest_q + HistAw'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      count_q   <= '0;
      oldest_q  <= '0;
      attempt_q <= '0;
      max_att_q <= MaxAttemptsReset;
      strobe_q  <= 1'b0;
      status_q  <= STATUS_ACCEPTED;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      count_q   <= count_d;
      oldest_q  <= oldest_d;
      attempt_q <= attempt_d;
      strobe_q  <= strobe_d;
      status_q  <= status_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_att_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cand_q <= {id_high_i, id_low_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= cand_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[idx_q[HistAw-1:0]];
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(HistDepth))
    else $error("history count beyond depth");

  a_ring_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != '0) |-> (count_q == CntW'(HistDepth)))
    else $error("ring pointer moved before history was full");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |-> (idx_q <= count_q))
    else $error("search index beyond stored entries");

  a_strobe_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q == ST_SEARCH) || $past(start && !busy)))
    else $error("status strobe without an item");

endmodule
